### hw/rtl/b64v_pkg.sv
// ----------------------------------------------------------------------------
// b64v_pkg
// Shared types, character codes and the symbol lookup for the base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64v_pkg;

	localparam int unsigned MaxCharsDefault = 65535;

	localparam logic [7:0] CharLf  = 8'h0A;
	localparam logic [7:0] CharCr  = 8'h0D;
	localparam logic [7:0] CharPad = 8'h3D;

	// symbol lookup results: 0..63 data, plus two marks
	localparam logic [6:0] CodePad = 7'd64;
	localparam logic [6:0] CodeBad = 7'd127;
	localparam logic [5:0] SymMask = 6'h3F;

	localparam logic [19:0] RoundUp = 20'd7;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_SMALL   = 2'd2
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	function automatic logic [6:0] sym_code(input logic [7:0] c);
		logic [6:0] code;
		code = CodeBad;
		priority if (c >= 8'h41 && c <= 8'h5A) begin
			code = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			code = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			code = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			code = 7'd62;
		end else if (c == 8'h2F) begin
			code = 7'd63;
		end else if (c == CharPad) begin
			code = CodePad;
		end else begin
			code = CodeBad;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/base64_decoder_with_validation_unit.sv
// ----------------------------------------------------------------------------
// base64_decoder_with_validation_unit
// Streaming base64 decoder: one character in, decoded bytes and an
// end-of-message status item out, with line-break skipping and validation.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tdata: in_char[7:0]; tlast: last
//  m_*      | out       | tdata: data_byte, status, byte_count; tuser: kind;
//           |           | tlast: last_result
//  cfg_*    | in        | cfg_wdata: output_capacity, written when cfg_wen
//
// A character is registered into the input stage, then decoded
// combinationally into the registered result buffer; results leave one per
// cycle while the output is ready. A character that gives several results
// holds the input stage until the single output port takes the last result
// in the buffer. Reset clears all message state and sets the capacity to
// 65535. A stalled output keeps the buffer full and back-pressures the
// input after one more character.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_decoder_with_validation_unit
	import b64v_pkg::*;
#(
	parameter int unsigned MAX_CHARS = MaxCharsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input characters
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_char
	input  wire logic        s_tlast,   // last
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] data_byte, [9:8] status,
	                                    // [25:10] byte_count, [31:26] zero
	output logic             m_tuser,   // kind
	output logic             m_tlast,   // last_result
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata
);

	localparam logic [15:0] SymLimit =
		(MAX_CHARS < 65535) ? 16'(MAX_CHARS) : 16'hFFFF;

	// configuration
	logic [15:0] capacity_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	// message state
	logic [23:0] acc_q;
	logic [1:0]  gpos_q;
	logic [1:0]  pad_q;
	logic [15:0] sym_q;
	logic [15:0] dec_q;
	logic        pcr_q;
	logic        err_q;

	// result buffer
	logic [7:0]  byte_q [3];
	logic [1:0]  nb_q;
	status_t     status_q;
	logic [15:0] count_q;
	logic [1:0]  ptr_q;
	logic [2:0]  rem_q;

	// decode results
	logic [23:0] acc_d;
	logic [1:0]  gpos_d;
	logic [1:0]  pad_d;
	logic [15:0] sym_d;
	logic [15:0] dec_d;
	logic        pcr_d;
	logic        err_d;
	logic [1:0]  nb_d;
	logic        skip;
	logic [6:0]  code;
	logic [16:0] dec_sum;
	logic [19:0] bound;
	status_t     status_d;
	logic [15:0] count_d;

	logic        s_accept;
	logic        m_accept;
	logic        buf_free;
	logic        advance;

	assign m_accept = m_tvalid && m_tready;
	assign buf_free = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_tready);
	assign advance  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		acc_d    = acc_q;
		gpos_d   = gpos_q;
		pad_d    = pad_q;
		sym_d    = sym_q;
		dec_d    = dec_q;
		pcr_d    = pcr_q;
		err_d    = err_q;
		nb_d     = 2'd0;
		skip     = 1'b0;
		code     = sym_code(char_s1);
		dec_sum  = 17'd0;
		bound    = 20'd0;
		status_d = ST_OK;
		count_d  = 16'd0;

		if (!err_q) begin
			if (pcr_q) begin
				pcr_d = 1'b0;
				if (char_s1 == CharLf) begin
					skip = 1'b1;
				end else begin
					err_d = 1'b1;
				end
			end
			if (!err_d && !skip) begin
				priority if (char_s1 == CharLf) begin
					// lone LF dropped
				end else if (char_s1 == CharCr) begin
					if (last_s1) begin
						err_d = 1'b1;
					end else begin
						pcr_d = 1'b1;
					end
				end else begin
					priority if (code == CodeBad) begin
						err_d = 1'b1;
					end else if (code == CodePad) begin
						if (pad_q >= 2'd2) begin
							err_d = 1'b1;
						end else begin
							pad_d = pad_q + 2'd1;
						end
					end else if (pad_q != 2'd0) begin
						err_d = 1'b1;
					end else begin
						pad_d = pad_q;
					end
					if (!err_d) begin
						acc_d = {acc_q[17:0], code[5:0] & SymMask};
						if (sym_q < SymLimit) begin
							sym_d = sym_q + 16'd1;
						end
						if (gpos_q == 2'd3) begin
							gpos_d  = 2'd0;
							nb_d    = 2'd3 - pad_d;
							dec_sum = {1'b0, dec_q} + {15'd0, nb_d};
							dec_d   = dec_sum[16] ? 16'hFFFF : dec_sum[15:0];
						end else begin
							gpos_d = gpos_q + 2'd1;
						end
					end
				end
			end
		end

		bound = ({4'd0, sym_d} * 20'd6 + RoundUp) >> 3;
		if (err_d) begin
			status_d = ST_INVALID;
			count_d  = dec_d;
		end else if (sym_d == 16'd0) begin
			status_d = ST_OK;
			count_d  = 16'd0;
		end else begin
			status_d = (bound > {4'd0, capacity_q}) ? ST_SMALL : ST_OK;
			count_d  = dec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hFFFF;
		end else if (cfg_wen) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			gpos_q <= '0;
			pad_q  <= '0;
			sym_q  <= '0;
			dec_q  <= '0;
			pcr_q  <= 1'b0;
			err_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				acc_q  <= '0;
				gpos_q <= '0;
				pad_q  <= '0;
				sym_q  <= '0;
				dec_q  <= '0;
				pcr_q  <= 1'b0;
				err_q  <= 1'b0;
			end else begin
				acc_q  <= acc_d;
				gpos_q <= gpos_d;
				pad_q  <= pad_d;
				sym_q  <= sym_d;
				dec_q  <= dec_d;
				pcr_q  <= pcr_d;
				err_q  <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			ptr_q <= 2'd0;
		end else if (advance) begin
			rem_q <= {1'b0, nb_d} + {2'd0, last_s1};
			ptr_q <= 2'd0;
		end else if (m_accept) begin
			rem_q <= rem_q - 3'd1;
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q[0] <= acc_d[23:16];
			byte_q[1] <= acc_d[15:8];
			byte_q[2] <= acc_d[7:0];
			nb_q      <= nb_d;
			status_q  <= status_d;
			count_q   <= count_d;
		end
	end

	// bytes come first, the status item (if any) after them
	always_comb begin
		m_tvalid = (rem_q != 3'd0);
		m_tdata  = '0;
		m_tuser  = KIND_DATA;
		m_tlast  = 1'b0;
		if (ptr_q < nb_q) begin
			unique case (ptr_q)
				2'd0:    m_tdata[7:0] = byte_q[0];
				2'd1:    m_tdata[7:0] = byte_q[1];
				default: m_tdata[7:0] = byte_q[2];
			endcase
		end else begin
			m_tuser        = KIND_STATUS;
			m_tlast        = 1'b1;
			m_tdata[9:8]   = status_q;
			m_tdata[25:10] = count_q;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/b64v_checker.sv
// ----------------------------------------------------------------------------
// b64v_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b64v_checker
	import b64v_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	// only the status item closes a message
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("tlast does not match item kind");

	// data items carry no status or count
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DATA) |-> (m_tdata[31:8] == 24'd0))
		else $error("data item with nonzero status fields");

	// status items: no byte, legal code, pad bits zero
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STATUS) |->
		(m_tdata[7:0] == 8'd0) && (m_tdata[9:8] != 2'b11) &&
		(m_tdata[31:26] == 6'd0))
		else $error("malformed status item");

endmodule

bind base64_decoder_with_validation_unit b64v_checker u_b64v_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
